FILE: rtl/vmmpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmmpd_pkg
// Shared types, codes and address constants of the memory and port decoder.
// ----------------------------------------------------------------------------
package vmmpd_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam int KQ_DEPTH = 16;
    localparam int KQ_AW    = (KQ_DEPTH > 1) ? $clog2(KQ_DEPTH) : 1;
    localparam int KQ_CW    = $clog2(KQ_DEPTH + 1);

    // Bus item kinds.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_KEY   = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 20;
    localparam logic [CFG_IW-1:0] CFG_ROM_WRITABLE   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RAM_CEILING_KB = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_STRICT_CEILING = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_DISPLAY_DELAY  = 2'd3;

    localparam logic [15:0] PORT_KBD    = 16'hD010;
    localparam logic [15:0] PORT_KBDCR  = 16'hD011;
    localparam logic [15:0] PORT_DSP    = 16'hD012;
    localparam logic [15:0] CASS_LO     = 16'hC000;
    localparam logic [15:0] CASS_HI     = 16'hC0FF;
    localparam logic [15:0] CASS_SKIP   = 16'hC081;
    localparam logic [15:0] MON_LO      = 16'hFF00;
    localparam logic [15:0] ROM1_LO     = 16'hC100;
    localparam logic [15:0] ROM1_HI     = 16'hC1FF;
    localparam logic [15:0] ROM2_LO     = 16'hE000;
    localparam logic [15:0] ROM2_HI     = 16'hEFFF;
    localparam logic [6:0]  CEIL_FULL   = 7'd64;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic        raw_key;
        logic [15:0] tick_cycles;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       display_strobe;
        logic [7:0] display_byte;
        logic       cassette_toggle;
        logic       out_of_range;
        logic       key_dropped;
    } out_item_t;

    // The D000-DFFF page mirrors the three adapter ports and the spare D013 byte.
    function automatic logic [15:0] fold_port(input logic [15:0] addr);
        logic [15:0] res;
        res = addr;
        if (addr[15:12] == 4'hD && addr != PORT_KBD && addr != PORT_KBDCR
            && addr != PORT_DSP) begin
            res = {PORT_KBD[15:2], addr[1:0]};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/vintage_micro_memory_and_pia_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vintage_micro_memory_and_pia_decode
// 64 KB memory with keyboard/display port decode, ROM protection and RAM
// ceiling checks for a small 6502 computer.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries bus reads, bus writes, key presses and cycle
// ticks; each transfer yields exactly one result transfer on the m_ channel.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wr_data
// by the user only while no item is in flight; the block does not enforce it.
// Result path: writes, key presses and ticks present their result in the cycle
// after the input transfer; reads pass through the registered memory read port
// and the ST_RDATA state before the output register. Writes, key presses and
// ticks are taken at one item per cycle while the receiver takes each result;
// a read blocks new items until its result is loaded in ST_RDATA.
// Reset: after aresetn is released the block clears all 65536 memory bytes,
// one per cycle, and holds s_ready low throughout the clear. Configuration
// writes are taken during the clear.
// Stalls: the result sits in an output register; the next item is taken in
// the same cycle the pending result is transferred, so a stalled receiver
// holds s_ready low.
// ----------------------------------------------------------------------------
module vintage_micro_memory_and_pia_decode (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire vmmpd_pkg::in_item_t          s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output vmmpd_pkg::out_item_t              m_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic [vmmpd_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [vmmpd_pkg::CFG_DW-1:0] cfg_wr_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RDATA = 2'd2;

    logic [7:0] mem [vmmpd_pkg::MEM_BYTES];
    logic [6:0] kq_mem [vmmpd_pkg::KQ_DEPTH];

    logic [1:0]                   state_reg, state_next;
    logic [vmmpd_pkg::MEM_AW-1:0] clr_addr_reg, clr_addr_next;

    logic        rom_writable_reg;
    logic [6:0]  ram_ceiling_reg;
    logic        strict_reg;
    logic [19:0] display_delay_reg;

    logic                        key_waiting_reg, key_waiting_next;
    logic [6:0]                  held_key_reg, held_key_next;
    logic [vmmpd_pkg::KQ_AW-1:0] kq_head_reg, kq_head_next;
    logic [vmmpd_pkg::KQ_AW-1:0] kq_tail_reg, kq_tail_next;
    logic [vmmpd_pkg::KQ_CW-1:0] kq_count_reg, kq_count_next;
    logic [19:0]                 busy_reg, busy_next;

    logic       rd_use_mem_reg, rd_use_mem_next;
    logic       rd_dsp_reg, rd_dsp_next;
    logic       rd_busy_reg, rd_busy_next;
    logic       rd_oor_reg, rd_oor_next;
    logic       rd_pop_reg, rd_pop_next;
    logic [7:0] rd_fixed_reg, rd_fixed_next;
    logic [7:0] mem_rdata_reg;
    logic [6:0] kq_rdata_reg;

    logic                out_valid_reg;
    vmmpd_pkg::out_item_t out_data_reg, out_next;
    logic                load_out;

    logic                         mem_we, mem_re;
    logic [vmmpd_pkg::MEM_AW-1:0] mem_waddr;
    logic [7:0]                   mem_wdata;
    logic                         kq_we, kq_re;
    logic [6:0]                   key_code;
    logic [7:0]                   key_fold;
    logic [15:0]                  addr_f;
    logic                         ceil_on, past, prot, accept;
    logic [19:0]                  tick_ext;

    assign s_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign tick_ext = {4'd0, s_data.tick_cycles};

    always_comb begin
        addr_f  = vmmpd_pkg::fold_port(s_data.address);
        ceil_on = (ram_ceiling_reg != 7'd0) && (ram_ceiling_reg < vmmpd_pkg::CEIL_FULL);
        // The ceiling is a whole number of kilobytes, so only address bits 15:10 matter.
        past    = ceil_on && !addr_f[15] && (addr_f[15:10] >= ram_ceiling_reg[5:0]);
        prot    = !rom_writable_reg && ((addr_f >= vmmpd_pkg::MON_LO)
                  || (addr_f >= vmmpd_pkg::ROM1_LO && addr_f <= vmmpd_pkg::ROM1_HI)
                  || (addr_f >= vmmpd_pkg::ROM2_LO && addr_f <= vmmpd_pkg::ROM2_HI));
        key_fold = s_data.data_byte;
        if (!s_data.raw_key && key_fold >= 8'h61 && key_fold <= 8'h7A) begin
            key_fold = key_fold - 8'h20;
        end
        key_code = key_fold[6:0];
    end

    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        key_waiting_next = key_waiting_reg;
        held_key_next    = held_key_reg;
        kq_head_next     = kq_head_reg;
        kq_tail_next     = kq_tail_reg;
        kq_count_next    = kq_count_reg;
        busy_next        = busy_reg;
        rd_use_mem_next  = rd_use_mem_reg;
        rd_dsp_next      = rd_dsp_reg;
        rd_busy_next     = rd_busy_reg;
        rd_oor_next      = rd_oor_reg;
        rd_pop_next      = rd_pop_reg;
        rd_fixed_next    = rd_fixed_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = addr_f;
        mem_wdata        = s_data.data_byte;
        kq_we            = 1'b0;
        kq_re            = 1'b0;
        load_out         = 1'b0;
        out_next         = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 8'h00;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {vmmpd_pkg::MEM_AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.action)
                        vmmpd_pkg::ACT_READ: begin
                            mem_re          = 1'b1;
                            state_next      = ST_RDATA;
                            rd_dsp_next     = (addr_f == vmmpd_pkg::PORT_DSP);
                            rd_busy_next    = (busy_reg != 20'd0);
                            rd_oor_next     = past;
                            rd_pop_next     = 1'b0;
                            rd_use_mem_next = 1'b1;
                            rd_fixed_next   = 8'hFF;
                            if (addr_f == vmmpd_pkg::PORT_KBD) begin
                                rd_use_mem_next = 1'b0;
                                rd_fixed_next   = key_waiting_reg ? {1'b1, held_key_reg} : 8'h00;
                                key_waiting_next = 1'b0;
                                if (kq_count_reg != '0) begin
                                    // The queued key arrives from the queue memory next cycle.
                                    kq_re            = 1'b1;
                                    rd_pop_next      = 1'b1;
                                    key_waiting_next = 1'b1;
                                    kq_count_next    = kq_count_reg - 1'b1;
                                    kq_head_next     = (kq_head_reg == vmmpd_pkg::KQ_AW'(vmmpd_pkg::KQ_DEPTH - 1))
                                                       ? '0 : kq_head_reg + 1'b1;
                                end
                            end else if (addr_f == vmmpd_pkg::PORT_KBDCR) begin
                                rd_use_mem_next = 1'b0;
                                rd_fixed_next   = key_waiting_reg ? 8'h80 : 8'h00;
                            end else if (past && strict_reg) begin
                                rd_use_mem_next = 1'b0;
                            end
                        end
                        vmmpd_pkg::ACT_WRITE: begin
                            load_out = 1'b1;
                            if (!prot) begin
                                out_next.cassette_toggle = (addr_f >= vmmpd_pkg::CASS_LO)
                                    && (addr_f <= vmmpd_pkg::CASS_HI)
                                    && (addr_f != vmmpd_pkg::CASS_SKIP);
                                if (addr_f == vmmpd_pkg::PORT_DSP) begin
                                    busy_next               = display_delay_reg;
                                    out_next.display_strobe = 1'b1;
                                    out_next.display_byte   = s_data.data_byte;
                                end
                                out_next.out_of_range = past;
                                mem_we = !(past && strict_reg);
                            end
                        end
                        vmmpd_pkg::ACT_KEY: begin
                            load_out = 1'b1;
                            if (!key_waiting_reg) begin
                                held_key_next    = key_code;
                                key_waiting_next = 1'b1;
                            end else if (kq_count_reg < vmmpd_pkg::KQ_CW'(vmmpd_pkg::KQ_DEPTH)) begin
                                kq_we         = 1'b1;
                                kq_count_next = kq_count_reg + 1'b1;
                                kq_tail_next  = (kq_tail_reg == vmmpd_pkg::KQ_AW'(vmmpd_pkg::KQ_DEPTH - 1))
                                                ? '0 : kq_tail_reg + 1'b1;
                            end else begin
                                out_next.key_dropped = 1'b1;
                            end
                        end
                        vmmpd_pkg::ACT_TICK: begin
                            load_out  = 1'b1;
                            busy_next = (busy_reg > tick_ext) ? busy_reg - tick_ext : 20'd0;
                        end
                    endcase
                end
            end
            ST_RDATA: begin
                load_out              = 1'b1;
                out_next.out_of_range = rd_oor_reg;
                if (rd_pop_reg) begin
                    held_key_next = kq_rdata_reg;
                end
                if (!rd_use_mem_reg) begin
                    out_next.read_data = rd_fixed_reg;
                end else if (rd_dsp_reg) begin
                    out_next.read_data = {rd_busy_reg, mem_rdata_reg[6:0]};
                end else begin
                    out_next.read_data = mem_rdata_reg;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Byte memory with one write port and one registered read port: the clear pass and bus writes share the write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[addr_f];
        end
        if (kq_we) begin
            kq_mem[kq_tail_reg] <= key_code;
        end
        if (kq_re) begin
            kq_rdata_reg <= kq_mem[kq_head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            rom_writable_reg  <= 1'b0;
            ram_ceiling_reg   <= vmmpd_pkg::CEIL_FULL;
            strict_reg        <= 1'b0;
            display_delay_reg <= 20'd0;
            key_waiting_reg   <= 1'b0;
            held_key_reg      <= 7'd0;
            kq_head_reg       <= '0;
            kq_tail_reg       <= '0;
            kq_count_reg      <= '0;
            busy_reg          <= 20'd0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            key_waiting_reg <= key_waiting_next;
            held_key_reg    <= held_key_next;
            kq_head_reg     <= kq_head_next;
            kq_tail_reg     <= kq_tail_next;
            kq_count_reg    <= kq_count_next;
            busy_reg        <= busy_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    vmmpd_pkg::CFG_ROM_WRITABLE:   rom_writable_reg  <= cfg_wr_data[0];
                    vmmpd_pkg::CFG_RAM_CEILING_KB: ram_ceiling_reg   <= cfg_wr_data[6:0];
                    vmmpd_pkg::CFG_STRICT_CEILING: strict_reg        <= cfg_wr_data[0];
                    vmmpd_pkg::CFG_DISPLAY_DELAY:  display_delay_reg <= cfg_wr_data[19:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_use_mem_reg <= rd_use_mem_next;
        rd_dsp_reg     <= rd_dsp_next;
        rd_busy_reg    <= rd_busy_next;
        rd_oor_reg     <= rd_oor_next;
        rd_pop_reg     <= rd_pop_next;
        rd_fixed_reg   <= rd_fixed_next;
        if (load_out) begin
            out_data_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

FILE: dv/vintage_micro_memory_and_pia_decode_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vintage_micro_memory_and_pia_decode_tb
// Self-checking bench for the memory and keyboard/display port decoder. A
// queue-fed driver offers bus reads, bus writes, key presses and ticks; every
// transfer is run through a behavioral copy of the decoder, and a monitor
// compares each result with the oldest prediction. The run steps through
// several register settings and sender/receiver idle patterns, including one
// long receiver stall.
// ----------------------------------------------------------------------------
module vintage_micro_memory_and_pia_decode_tb;
    import vmmpd_pkg::*;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int SQUEEZE_CYCLES  = 300;
    localparam logic [15:0] RAM_TOP  = 16'h8000;
    localparam logic [7:0]  LOWER_A  = 8'h61;
    localparam logic [7:0]  LOWER_Z  = 8'h7A;
    localparam logic [7:0]  CASE_GAP = 8'h20;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_item_t          s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_item_t         m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_IW-1:0] cfg_index   = '0;
    logic [CFG_DW-1:0] cfg_wr_data = '0;

    vintage_micro_memory_and_pia_decode dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // Behavioral copy of the decoder state and its register settings.
    logic [7:0]  mem_image [0:MEM_BYTES-1];
    logic        kbd_full    = 1'b0;
    logic [6:0]  kbd_latch   = '0;
    logic [6:0]  kbd_backlog [$];
    logic [19:0] busy_left   = '0;
    logic        rom_open    = 1'b0;
    logic [6:0]  ceiling_kb  = CEIL_FULL;
    logic        strict_mode = 1'b0;
    logic [19:0] dsp_delay   = '0;

    in_item_t  bus_items [$];
    out_item_t awaited_replies [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic squeeze_armed = 1'b0;
    logic squeeze_done  = 1'b0;
    int squeeze_left    = 0;
    int cycle_count     = 0;
    int queued          = 0;
    int mismatches      = 0;
    int settings_used   = 0;
    int action_count [4] = '{0, 0, 0, 0};
    int n_strobes = 0, n_ceiling = 0, n_toggles = 0, n_dropped = 0;

    function automatic logic beyond_ram(input logic [15:0] a);
        logic hit;
        hit = 1'b0;
        if (ceiling_kb != 7'd0 && ceiling_kb < CEIL_FULL) begin
            hit = ({1'b0, a} >= {ceiling_kb, 10'd0}) && (a < RAM_TOP);
        end
        return hit;
    endfunction

    function automatic out_item_t decode_bus_item(input in_item_t it);
        out_item_t res;
        logic [15:0] a;
        logic [7:0] k;
        logic locked;
        res = '0;
        a = it.address;
        // Everything in the D page lands on the three ports or the spare byte.
        if (a[15:12] == 4'hD) begin
            a = PORT_KBD | {14'd0, it.address[1:0]};
        end
        case (it.action)
            ACT_READ: begin
                if (a == PORT_KBD) begin
                    res.read_data = kbd_full ? {1'b1, kbd_latch} : 8'h00;
                    kbd_full = 1'b0;
                    if (kbd_backlog.size() != 0) begin
                        kbd_latch = kbd_backlog.pop_front();
                        kbd_full = 1'b1;
                    end
                end else if (a == PORT_DSP) begin
                    res.read_data = {busy_left != 20'd0, mem_image[a][6:0]};
                end else if (a == PORT_KBDCR) begin
                    res.read_data = {kbd_full, 7'd0};
                end else if (beyond_ram(a)) begin
                    res.out_of_range = 1'b1;
                    res.read_data = strict_mode ? 8'hFF : mem_image[a];
                end else begin
                    res.read_data = mem_image[a];
                end
            end
            ACT_WRITE: begin
                locked = !rom_open && (a >= MON_LO || (a >= ROM1_LO && a <= ROM1_HI)
                         || (a >= ROM2_LO && a <= ROM2_HI));
                if (!locked) begin
                    res.cassette_toggle = (a >= CASS_LO && a <= CASS_HI && a != CASS_SKIP);
                    if (a == PORT_DSP) begin
                        busy_left = dsp_delay;
                        res.display_strobe = 1'b1;
                        res.display_byte = it.data_byte;
                    end
                    if (beyond_ram(a)) begin
                        res.out_of_range = 1'b1;
                    end
                    if (!(res.out_of_range && strict_mode)) begin
                        mem_image[a] = it.data_byte;
                    end
                end
            end
            ACT_KEY: begin
                k = it.data_byte;
                if (!it.raw_key && k >= LOWER_A && k <= LOWER_Z) begin
                    k = k - CASE_GAP;
                end
                if (!kbd_full) begin
                    kbd_latch = k[6:0];
                    kbd_full = 1'b1;
                end else if (kbd_backlog.size() < KQ_DEPTH) begin
                    kbd_backlog.push_back(k[6:0]);
                end else begin
                    res.key_dropped = 1'b1;
                end
            end
            default: begin
                busy_left = (busy_left > {4'd0, it.tick_cycles})
                            ? busy_left - {4'd0, it.tick_cycles} : 20'd0;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic put(input logic [1:0] act, input logic [15:0] a, input logic [7:0] d,
                       input logic raw, input logic [15:0] ticks);
        in_item_t it;
        it.action = act;
        it.address = a;
        it.data_byte = d;
        it.raw_key = raw;
        it.tick_cycles = ticks;
        bus_items.push_back(it);
        queued++;
    endtask

    function automatic logic [15:0] port_alias(input logic [15:0] port);
        logic [15:0] a;
        a = $urandom_range(1) ? port : {4'hD, 10'($urandom), port[1:0]};
        return a;
    endfunction

    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        int border;
        border = int'(ceiling_kb) * 1024;
        case ($urandom_range(6))
            0: a = 16'(border - 2 + int'($urandom_range(3)));
            1: a = 16'($urandom_range(32'h7FFF));
            2: a = {MON_LO[15:8], 8'($urandom)};
            3: a = $urandom_range(1) ? {ROM1_LO[15:8], 8'($urandom)}
                                      : {ROM2_LO[15:12], 12'($urandom)};
            4: a = ($urandom_range(3) == 0) ? CASS_SKIP : {CASS_LO[15:8], 8'($urandom)};
            5: a = {4'hD, 12'($urandom)};
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    // Mostly well-formed traffic: key bursts drained through the keyboard port,
    // display writes with polling and ticks, and write/read-back pairs, with
    // fully random items mixed in.
    task automatic fill_traffic(input int target);
        int stop_at, pick, j;
        logic [15:0] a;
        stop_at = queued + target;
        while (queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                put(2'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
            end else if (pick < 45) begin
                repeat ($urandom_range(1, 20)) begin
                    put(ACT_KEY, 16'($urandom),
                        $urandom_range(1) ? 8'(LOWER_A + 8'($urandom_range(25))) : 8'($urandom),
                        1'($urandom), 16'($urandom));
                end
                repeat ($urandom_range(0, 20)) begin
                    a = port_alias($urandom_range(3) == 0 ? PORT_KBDCR : PORT_KBD);
                    put(ACT_READ, a, 8'($urandom), 1'($urandom), 16'($urandom));
                end
            end else if (pick < 65) begin
                put(ACT_WRITE, port_alias(PORT_DSP), 8'($urandom), 1'($urandom), 16'($urandom));
                repeat ($urandom_range(1, 6)) begin
                    j = $urandom_range(2);
                    if (j == 0) begin
                        put(ACT_READ, port_alias(PORT_DSP), 8'($urandom), 1'($urandom),
                            16'($urandom));
                    end else begin
                        put(ACT_TICK, 16'($urandom), 8'($urandom), 1'($urandom),
                            j == 1 ? 16'($urandom_range(40)) : 16'($urandom));
                    end
                end
            end else begin
                a = pick_addr();
                if ($urandom_range(3) != 0) begin
                    put(ACT_WRITE, a, 8'($urandom), 1'($urandom), 16'($urandom));
                end
                put(ACT_READ, a, 8'($urandom), 1'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (bus_items.size() != 0 || s_valid || awaited_replies.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            CFG_ROM_WRITABLE:   rom_open = val[0];
            CFG_RAM_CEILING_KB: ceiling_kb = val[6:0];
            CFG_STRICT_CEILING: strict_mode = val[0];
            default:            dsp_delay = val;
        endcase
    endtask

    task automatic apply_settings(input logic rom, input logic [6:0] kb, input logic strict,
                                  input logic [19:0] delay);
        wait_drained();
        write_reg(CFG_ROM_WRITABLE, 20'(rom));
        write_reg(CFG_RAM_CEILING_KB, 20'(kb));
        write_reg(CFG_STRICT_CEILING, 20'(strict));
        write_reg(CFG_DISPLAY_DELAY, delay);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic rom, input logic [6:0] kb, input logic strict,
                             input logic [19:0] delay, input int send_pct, input int recv_pct,
                             input int count, input logic squeeze);
        apply_settings(rom, kb, strict, delay);
        @(negedge aclk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        squeeze_armed = squeeze;
        fill_traffic(count);
    endtask

    // Sender: predicts each transfer as it happens, then offers the next item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_replies.push_back(decode_bus_item(s_data));
                action_count[s_data.action]++;
            end
            if (!s_valid || s_ready) begin
                if (bus_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= bus_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver stall so the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            squeeze_left <= 0;
            squeeze_done <= 1'b0;
        end else if (squeeze_armed && !squeeze_done) begin
            squeeze_left <= SQUEEZE_CYCLES;
            squeeze_done <= 1'b1;
        end else if (squeeze_left != 0) begin
            squeeze_left <= squeeze_left - 1;
        end
    end

    always @(posedge aclk) begin : reply_check
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch("unrequested result", int'(m_data), 0);
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_data.read_data != want.read_data)
                        report_mismatch("read_data", int'(m_data.read_data),
                                        int'(want.read_data));
                    if (m_data.display_strobe != want.display_strobe)
                        report_mismatch("display_strobe", int'(m_data.display_strobe),
                                        int'(want.display_strobe));
                    if (m_data.display_byte != want.display_byte)
                        report_mismatch("display_byte", int'(m_data.display_byte),
                                        int'(want.display_byte));
                    if (m_data.cassette_toggle != want.cassette_toggle)
                        report_mismatch("cassette_toggle", int'(m_data.cassette_toggle),
                                        int'(want.cassette_toggle));
                    if (m_data.out_of_range != want.out_of_range)
                        report_mismatch("out_of_range", int'(m_data.out_of_range),
                                        int'(want.out_of_range));
                    if (m_data.key_dropped != want.key_dropped)
                        report_mismatch("key_dropped", int'(m_data.key_dropped),
                                        int'(want.key_dropped));
                    n_strobes += int'(want.display_strobe);
                    n_ceiling += int'(want.out_of_range);
                    n_toggles += int'(want.cassette_toggle);
                    n_dropped += int'(want.key_dropped);
                end
            end
            m_ready <= (squeeze_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("vintage_micro_memory_and_pia_decode_tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        for (i = 0; i < MEM_BYTES; i++) begin
            mem_image[i] = 8'h00;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Protection, cassette page, display busy and keyboard latch basics.
        apply_settings(1'b0, CEIL_FULL, 1'b0, 20'd5);
        @(negedge aclk);
        send_idle_pct = 37;
        recv_idle_pct = 48;
        put(ACT_WRITE, MON_LO, 8'hAA, 1'b0, 16'd0);
        put(ACT_READ, MON_LO, 8'h00, 1'b0, 16'd0);
        put(ACT_WRITE, ROM1_HI, 8'h11, 1'b0, 16'd0);
        put(ACT_WRITE, ROM2_LO, 8'h22, 1'b0, 16'd0);
        put(ACT_WRITE, CASS_LO, 8'h5A, 1'b0, 16'd0);
        put(ACT_WRITE, CASS_SKIP, 8'h33, 1'b0, 16'd0);
        put(ACT_READ, CASS_LO, 8'h00, 1'b0, 16'd0);
        put(ACT_WRITE, PORT_DSP, 8'hC1, 1'b0, 16'd0);
        put(ACT_READ, PORT_DSP, 8'h00, 1'b0, 16'd0);
        put(ACT_TICK, 16'h0000, 8'h00, 1'b0, 16'd3);
        put(ACT_READ, 16'hD0F2, 8'h00, 1'b0, 16'd0);
        put(ACT_TICK, 16'h0000, 8'h00, 1'b0, 16'hFFFF);
        put(ACT_READ, PORT_DSP, 8'h00, 1'b0, 16'd0);
        put(ACT_KEY, 16'h0000, LOWER_A, 1'b0, 16'd0);
        put(ACT_KEY, 16'h0000, LOWER_A, 1'b1, 16'd0);
        put(ACT_KEY, 16'h0000, 8'hFF, 1'b0, 16'd0);
        put(ACT_READ, PORT_KBDCR, 8'h00, 1'b0, 16'd0);
        put(ACT_READ, PORT_KBD, 8'h00, 1'b0, 16'd0);
        put(ACT_READ, 16'hD0F0, 8'h00, 1'b0, 16'd0);
        put(ACT_READ, PORT_KBD, 8'h00, 1'b0, 16'd0);
        put(ACT_READ, PORT_KBD, 8'h00, 1'b0, 16'd0);
        put(ACT_WRITE, 16'hD003, 8'h55, 1'b0, 16'd0);
        put(ACT_READ, 16'hDFF7, 8'h00, 1'b0, 16'd0);

        // Open ROM, smallest strict RAM ceiling, longest display delay.
        apply_settings(1'b1, 7'd1, 1'b1, 20'hFFFFF);
        @(negedge aclk);
        put(ACT_WRITE, MON_LO, 8'hAA, 1'b0, 16'd0);
        put(ACT_READ, MON_LO, 8'h00, 1'b0, 16'd0);
        put(ACT_WRITE, 16'h0400, 8'h77, 1'b0, 16'd0);
        put(ACT_READ, 16'h0400, 8'h00, 1'b0, 16'd0);
        put(ACT_READ, RAM_TOP - 16'd1, 8'h00, 1'b0, 16'd0);

        run_phase(1'b0, CEIL_FULL, 1'b0, 20'd0, 37, 48, 305, 1'b0);
        run_phase(1'b1, 7'd1, 1'b1, 20'hFFFFF, 37, 48, 305, 1'b0);
        run_phase(1'b0, 7'd32, 1'b0, 20'd100, 48, 37, 305, 1'b0);
        run_phase(1'b1, 7'd0, 1'b1, 20'd7, 48, 37, 305, 1'b0);
        run_phase(1'b0, 7'd17, 1'b1, 20'd300, 0, 0, 305, 1'b1);
        run_phase(1'b1, 7'd100, 1'b0, 20'd2, 0, 0, 305, 1'b0);

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("Covered %0d reads, %0d writes, %0d key presses and %0d ticks over %0d settings.",
                 action_count[ACT_READ], action_count[ACT_WRITE], action_count[ACT_KEY],
                 action_count[ACT_TICK], settings_used);
        $display("Saw %0d display strobes, %0d ceiling hits, %0d cassette toggles, %0d lost keys.",
                 n_strobes, n_ceiling, n_toggles, n_dropped);
        if (mismatches == 0) begin
            $display("vintage_micro_memory_and_pia_decode_tb: clean");
        end else begin
            $display("vintage_micro_memory_and_pia_decode_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/vmmpd_pkg.sv
rtl/vintage_micro_memory_and_pia_decode.sv
dv/vintage_micro_memory_and_pia_decode_tb.sv
